// ----- rtl/stack_alu_engine_core_defines.svh -----
// Assertion macros shared by the stack engine RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef STACK_ALU_ENGINE_CORE_DEFINES_SVH
`define STACK_ALU_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SAE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SAE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SAE_ASSERT(lbl, clk, rst, prop, msg)
`define SAE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/sae_pkg.sv -----
// Types and constants of the stack engine: opcodes, status codes, states.
// No dependencies; used by every module of the block.
package sae_pkg;

   localparam int WORD_W      = 32;
   localparam int DEPTH_OUT_W = 7;
   localparam int LOOP_STEPS  = 32;
   localparam int LOOP_CNT_W  = $clog2(LOOP_STEPS);

   typedef enum logic [3:0] {
      OP_PUSH = 4'd0,
      OP_POP  = 4'd1,
      OP_SWAP = 4'd2,
      OP_PEEK = 4'd3,
      OP_ADD  = 4'd4,
      OP_SUB  = 4'd5,
      OP_MUL  = 4'd6,
      OP_DIV  = 4'd7,
      OP_MOD  = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_ZERO  = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_SWAP,
      S_EXEC,
      S_DONE
   } seq_state_type;

   typedef enum logic [2:0] {
      A_IDLE,
      A_ADD,
      A_NEGA,
      A_NEGB,
      A_LOOP,
      A_FIX,
      A_DONE
   } alu_state_type;

   typedef struct packed {
      logic              start;
      op_type            op;
      logic [WORD_W-1:0] lhs;
      logic [WORD_W-1:0] rhs;
   } alu_req_type;

   typedef struct packed {
      logic              done;
      logic [WORD_W-1:0] result;
   } alu_rsp_type;

endpackage

// ----- rtl/sae_stack_mem.sv -----
// Operand stack storage: one write port and one registered read port.
// Depends on sae_pkg for the word width.
module sae_stack_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [sae_pkg::WORD_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic [sae_pkg::WORD_W-1:0] rd_data
);

   logic [sae_pkg::WORD_W-1:0] mem [DEPTH];
   logic [sae_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/sae_alu.sv -----
// Shared 33-bit adder under a small sequencer: add, sub, shift-add multiply,
// and restoring signed divide/modulo. Depends on sae_pkg and the defines header.
`include "stack_alu_engine_core_defines.svh"

module sae_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  sae_pkg::alu_req_type alu_req,
   output sae_pkg::alu_rsp_type alu_rsp
);

   sae_pkg::alu_state_type state_ff, state_in;
   sae_pkg::op_type        op_ff, op_in;
   logic [sae_pkg::WORD_W:0]       acc_ff, acc_in;
   logic [sae_pkg::WORD_W-1:0]     quo_ff, quo_in;
   logic [sae_pkg::WORD_W-1:0]     b_ff, b_in;
   logic [sae_pkg::WORD_W-1:0]     res_ff, res_in;
   logic                           an_ff, an_in;
   logic                           bn_ff, bn_in;
   logic [sae_pkg::LOOP_CNT_W-1:0] cnt_ff, cnt_in;

   logic [sae_pkg::WORD_W:0]   add_x, add_y, shifted;
   logic                       add_cin;
   logic [sae_pkg::WORD_W+1:0] add_sum;
   logic [sae_pkg::WORD_W-1:0] fix_val;
   logic                       fix_neg;
   logic                       carry;

   localparam logic [sae_pkg::LOOP_CNT_W-1:0] CNT_LAST =
      sae_pkg::LOOP_CNT_W'(sae_pkg::LOOP_STEPS - 1);

   assign add_sum = {1'b0, add_x} + {1'b0, add_y} + {{(sae_pkg::WORD_W + 1){1'b0}}, add_cin};
   assign carry   = add_sum[sae_pkg::WORD_W+1];
   assign shifted = {acc_ff[sae_pkg::WORD_W-1:0], quo_ff[sae_pkg::WORD_W-1]};

   always_comb begin
      fix_val = (op_ff == sae_pkg::OP_DIV) ? quo_ff : acc_ff[sae_pkg::WORD_W-1:0];
      case (op_ff)
         sae_pkg::OP_DIV: fix_neg = an_ff ^ bn_ff;
         sae_pkg::OP_MOD: fix_neg = an_ff;
         default:         fix_neg = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sae_pkg::A_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff  <= op_in;
      acc_ff <= acc_in;
      quo_ff <= quo_in;
      b_ff   <= b_in;
      res_ff <= res_in;
      an_ff  <= an_in;
      bn_ff  <= bn_in;
      cnt_ff <= cnt_in;
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      acc_in   = acc_ff;
      quo_in   = quo_ff;
      b_in     = b_ff;
      res_in   = res_ff;
      an_in    = an_ff;
      bn_in    = bn_ff;
      cnt_in   = cnt_ff;
      add_x    = '0;
      add_y    = '0;
      add_cin  = 1'b0;
      case (state_ff)
         sae_pkg::A_IDLE: begin
            if (alu_req.start) begin
               op_in  = alu_req.op;
               quo_in = alu_req.lhs;
               b_in   = alu_req.rhs;
               an_in  = alu_req.lhs[sae_pkg::WORD_W-1];
               bn_in  = alu_req.rhs[sae_pkg::WORD_W-1];
               acc_in = '0;
               cnt_in = '0;
               case (alu_req.op)
                  sae_pkg::OP_MUL: state_in = sae_pkg::A_LOOP;
                  sae_pkg::OP_DIV,
                  sae_pkg::OP_MOD: state_in = sae_pkg::A_NEGA;
                  default:         state_in = sae_pkg::A_ADD;
               endcase
            end
         end
         sae_pkg::A_ADD: begin
            add_x = {1'b0, quo_ff};
            if (op_ff == sae_pkg::OP_SUB) begin
               add_y   = {1'b0, ~b_ff};
               add_cin = 1'b1;
            end else begin
               add_y = {1'b0, b_ff};
            end
            res_in   = add_sum[sae_pkg::WORD_W-1:0];
            state_in = sae_pkg::A_DONE;
         end
         sae_pkg::A_NEGA: begin
            // Dividend magnitude: two's complement negate through the adder.
            add_y   = {1'b0, ~quo_ff};
            add_cin = 1'b1;
            if (an_ff) begin
               quo_in = add_sum[sae_pkg::WORD_W-1:0];
            end
            state_in = sae_pkg::A_NEGB;
         end
         sae_pkg::A_NEGB: begin
            add_y   = {1'b0, ~b_ff};
            add_cin = 1'b1;
            if (bn_ff) begin
               b_in = add_sum[sae_pkg::WORD_W-1:0];
            end
            state_in = sae_pkg::A_LOOP;
         end
         sae_pkg::A_LOOP: begin
            if (op_ff == sae_pkg::OP_MUL) begin
               add_x  = {1'b0, acc_ff[sae_pkg::WORD_W-1:0]};
               add_y  = quo_ff[0] ? {1'b0, b_ff} : '0;
               acc_in = add_sum[sae_pkg::WORD_W:0];
               b_in   = {b_ff[sae_pkg::WORD_W-2:0], 1'b0};
               quo_in = {1'b0, quo_ff[sae_pkg::WORD_W-1:1]};
            end else begin
               // Trial subtraction; the carry out says the divisor fits.
               add_x   = shifted;
               add_y   = ~{1'b0, b_ff};
               add_cin = 1'b1;
               acc_in  = carry ? add_sum[sae_pkg::WORD_W:0] : shifted;
               quo_in  = {quo_ff[sae_pkg::WORD_W-2:0], carry};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = sae_pkg::A_FIX;
            end
         end
         sae_pkg::A_FIX: begin
            add_y    = {1'b0, ~fix_val};
            add_cin  = 1'b1;
            res_in   = fix_neg ? add_sum[sae_pkg::WORD_W-1:0] : fix_val;
            state_in = sae_pkg::A_DONE;
         end
         sae_pkg::A_DONE: begin
            state_in = sae_pkg::A_IDLE;
         end
         default: begin
            state_in = sae_pkg::A_IDLE;
         end
      endcase
   end

   assign alu_rsp.done   = (state_ff == sae_pkg::A_DONE);
   assign alu_rsp.result = res_ff;

   `SAE_ASSERT(a_start_when_idle, clock, reset, alu_req.start |-> state_ff == sae_pkg::A_IDLE, "ALU started while busy")
   `SAE_ASSERT(a_loop_ends, clock, reset, (state_ff == sae_pkg::A_LOOP && cnt_ff == CNT_LAST) |=> state_ff == sae_pkg::A_FIX, "ALU loop overran")

endmodule

// ----- rtl/stack_alu_engine_core.sv -----
// Stack engine: one opcode per transaction, one result per transaction.
// Push, peek and errors go straight to the result; pop and swap pass through
// fetch, arithmetic through fetch and the ALU, whose mul, div and mod run the
// 32-step loop. A new request is taken in the cycle after the result is loaded.
// Synchronous reset empties the stack; stack storage itself is not cleared.
`include "stack_alu_engine_core_defines.svh"

module stack_alu_engine_core #(
   parameter int STACK_DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [3:0]                        req_type,
   input  logic signed [sae_pkg::WORD_W-1:0] req_push_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic signed [sae_pkg::WORD_W-1:0] rsp_top_value,
   output logic [sae_pkg::DEPTH_OUT_W-1:0]   rsp_depth_now
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int OW = sae_pkg::DEPTH_OUT_W;

   sae_pkg::seq_state_type state_ff, state_in;
   sae_pkg::op_type        op_ff, op_in;
   sae_pkg::status_type    status_ff, status_in;
   logic [CW-1:0]              count_ff, count_in;
   logic [sae_pkg::WORD_W-1:0] top_ff, top_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_status_ff;
   logic [sae_pkg::WORD_W-1:0] rsp_top_ff;
   logic [OW-1:0]              rsp_depth_ff;
   logic                       rsp_load;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr, addr_m1, addr_m2;
   logic [sae_pkg::WORD_W-1:0] wr_data, rd_data;
   logic [OW-1:0]              depth_out;
   logic                       is_full, is_empty, is_short;

   sae_pkg::alu_req_type alu_req;
   sae_pkg::alu_rsp_type alu_rsp;

   assign addr_m1  = AW'(count_ff - CW'(1));
   assign addr_m2  = AW'(count_ff - CW'(2));
   assign is_full  = (count_ff == CW'(STACK_DEPTH));
   assign is_empty = (count_ff == '0);
   assign is_short = (count_ff < CW'(2));

   generate
      if (CW >= OW) begin : g_depth_trunc
         assign depth_out = count_ff[OW-1:0];
      end else begin : g_depth_ext
         assign depth_out = {{(OW - CW){1'b0}}, count_ff};
      end
   endgenerate

   sae_stack_mem #(
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_m2),
      .rd_data (rd_data)
   );

   sae_alu u_alu (
      .clock   (clock),
      .reset   (reset),
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sae_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff     <= op_in;
      status_ff <= status_in;
      top_ff    <= top_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_top_ff    <= is_empty ? '0 : top_ff;
         rsp_depth_ff  <= depth_out;
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      status_in     = status_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_m2;
      wr_data       = top_ff;
      alu_req.start = 1'b0;
      alu_req.op    = op_ff;
      alu_req.lhs   = rd_data;
      alu_req.rhs   = top_ff;
      rsp_load      = 1'b0;
      case (state_ff)
         sae_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in     = sae_pkg::op_type'(req_type);
               status_in = sae_pkg::ST_OK;
               state_in  = sae_pkg::S_DONE;
               case (sae_pkg::op_type'(req_type))
                  sae_pkg::OP_PUSH: begin
                     if (is_full) begin
                        status_in = sae_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_push_value;
                        top_in   = req_push_value;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  sae_pkg::OP_POP: begin
                     if (is_empty) status_in = sae_pkg::ST_SHORT;
                     else          state_in  = sae_pkg::S_FETCH;
                  end
                  sae_pkg::OP_PEEK: begin
                     if (is_empty) status_in = sae_pkg::ST_SHORT;
                  end
                  sae_pkg::OP_SWAP, sae_pkg::OP_ADD, sae_pkg::OP_SUB, sae_pkg::OP_MUL: begin
                     if (is_short) status_in = sae_pkg::ST_SHORT;
                     else          state_in  = sae_pkg::S_FETCH;
                  end
                  sae_pkg::OP_DIV, sae_pkg::OP_MOD: begin
                     // Depth is checked ahead of the divisor.
                     if (is_short)          status_in = sae_pkg::ST_SHORT;
                     else if (top_ff == '0) status_in = sae_pkg::ST_ZERO;
                     else                   state_in  = sae_pkg::S_FETCH;
                  end
                  default: begin
                  end
               endcase
            end
         end
         sae_pkg::S_FETCH: begin
            // The second entry arrived from the read issued at acceptance.
            case (op_ff)
               sae_pkg::OP_POP: begin
                  top_in   = rd_data;
                  count_in = count_ff - 1'b1;
                  state_in = sae_pkg::S_DONE;
               end
               sae_pkg::OP_SWAP: begin
                  wr_en    = 1'b1;
                  wr_addr  = addr_m2;
                  wr_data  = top_ff;
                  top_in   = rd_data;
                  state_in = sae_pkg::S_SWAP;
               end
               default: begin
                  alu_req.start = 1'b1;
                  state_in      = sae_pkg::S_EXEC;
               end
            endcase
         end
         sae_pkg::S_SWAP: begin
            wr_en    = 1'b1;
            wr_addr  = addr_m1;
            wr_data  = top_ff;
            state_in = sae_pkg::S_DONE;
         end
         sae_pkg::S_EXEC: begin
            if (alu_rsp.done) begin
               wr_en    = 1'b1;
               wr_addr  = addr_m2;
               wr_data  = alu_rsp.result;
               top_in   = alu_rsp.result;
               count_in = count_ff - 1'b1;
               state_in = sae_pkg::S_DONE;
            end
         end
         sae_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = sae_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sae_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall     = (state_ff != sae_pkg::S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_top_value = rsp_top_ff;
   assign rsp_depth_now = rsp_depth_ff;

   `SAE_ASSERT(a_depth_bound, clock, reset, count_ff <= CW'(STACK_DEPTH), "stack depth out of range")
   `SAE_ASSERT(a_accept_leaves_idle, clock, reset, (req_valid && !req_stall) |=> state_ff != sae_pkg::S_IDLE, "accepted transaction not started")
   `SAE_ASSERT(a_done_in_exec, clock, reset, alu_rsp.done |-> state_ff == sae_pkg::S_EXEC, "ALU result outside execute")
   `SAE_ASSERT(a_count_held_in_exec, clock, reset, (state_ff == sae_pkg::S_EXEC && !alu_rsp.done) |=> $stable(count_ff), "depth changed during ALU work")

endmodule

// ----- verif/stack_view_checker.sv -----
// Checker for the stack engine: watches both channels, keeps its own copy of the stack
// and compares every result transaction with the predicted status, top and depth.
// Depends on sae_pkg for the opcode and status codes.
module stack_view_checker #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [3:0]                        req_type,
   input  logic signed [sae_pkg::WORD_W-1:0] req_push_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [1:0]                        rsp_status,
   input  logic signed [sae_pkg::WORD_W-1:0] rsp_top_value,
   input  logic [sae_pkg::DEPTH_OUT_W-1:0]   rsp_depth_now,
   output int                                fail_count,
   output int                                pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import sae_pkg::*;

   localparam int PRINT_CAP = 60;

   typedef struct {
      status_type               status;
      logic [WORD_W-1:0]        top;
      logic [DEPTH_OUT_W-1:0]   depth;
   } stack_view_t;

   logic [WORD_W-1:0] stack_mem [DEPTH];
   int                stack_depth;
   stack_view_t       pending_views [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      stack_depth   = 0;
   end

   task automatic report_mismatch(input string msg);
      if (fail_count < PRINT_CAP) begin
         $display("[%0t] checker: %s", $time, msg);
      end
      fail_count++;
   endtask

   // Signed divide on magnitudes: the quotient truncates toward zero and the
   // remainder follows the dividend, so the most negative word over -1 wraps.
   function automatic logic [WORD_W-1:0] signed_divmod(input logic [WORD_W-1:0] lhs,
                                                       input logic [WORD_W-1:0] rhs,
                                                       input bit want_rem);
      logic [WORD_W-1:0] mag_l;
      logic [WORD_W-1:0] mag_r;
      logic [WORD_W-1:0] quo;
      logic [WORD_W-1:0] rem;
      mag_l = lhs[WORD_W-1] ? -lhs : lhs;
      mag_r = rhs[WORD_W-1] ? -rhs : rhs;
      quo   = mag_l / mag_r;
      rem   = mag_l % mag_r;
      if (want_rem) begin
         return lhs[WORD_W-1] ? -rem : rem;
      end
      return (lhs[WORD_W-1] ^ rhs[WORD_W-1]) ? -quo : quo;
   endfunction

   function automatic stack_view_t apply_opcode(input logic [3:0] opc,
                                                input logic [WORD_W-1:0] word);
      stack_view_t       view;
      logic [WORD_W-1:0] lhs;
      logic [WORD_W-1:0] rhs;
      logic [WORD_W-1:0] res;
      view.status = ST_OK;
      case (opc)
         OP_PUSH: begin
            if (stack_depth >= DEPTH) begin
               view.status = ST_FULL;
            end else begin
               stack_mem[stack_depth] = word;
               stack_depth++;
            end
         end
         OP_POP: begin
            if (stack_depth == 0) view.status = ST_SHORT;
            else stack_depth--;
         end
         OP_SWAP: begin
            if (stack_depth < 2) begin
               view.status = ST_SHORT;
            end else begin
               res                        = stack_mem[stack_depth-1];
               stack_mem[stack_depth-1] = stack_mem[stack_depth-2];
               stack_mem[stack_depth-2] = res;
            end
         end
         OP_PEEK: begin
            if (stack_depth == 0) view.status = ST_SHORT;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
            if (stack_depth < 2) begin
               view.status = ST_SHORT;
            end else begin
               rhs = stack_mem[stack_depth-1];
               lhs = stack_mem[stack_depth-2];
               if ((opc == OP_DIV || opc == OP_MOD) && rhs == '0) begin
                  view.status = ST_ZERO;
               end else begin
                  case (opc)
                     OP_ADD:  res = lhs + rhs;
                     OP_SUB:  res = lhs - rhs;
                     OP_MUL:  res = lhs * rhs;
                     OP_DIV:  res = signed_divmod(lhs, rhs, 1'b0);
                     default: res = signed_divmod(lhs, rhs, 1'b1);
                  endcase
                  stack_depth--;
                  stack_mem[stack_depth-1] = res;
               end
            end
         end
         default: ;
      endcase
      view.top   = (stack_depth > 0) ? stack_mem[stack_depth-1] : '0;
      view.depth = DEPTH_OUT_W'(stack_depth);
      return view;
   endfunction

   always @(posedge clock) begin
      stack_view_t want;
      if (reset) begin
         stack_depth = 0;
         pending_views.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_views.size() == 0) begin
               report_mismatch($sformatf("result transaction with nothing expected: st=%0d top=%h dep=%0d",
                                         rsp_status, rsp_top_value, rsp_depth_now));
            end else begin
               want = pending_views.pop_front();
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d", rsp_status, want.status));
               end
               if (rsp_top_value !== want.top) begin
                  report_mismatch($sformatf("top_value %h, expected %h", rsp_top_value, want.top));
               end
               if (rsp_depth_now !== want.depth) begin
                  report_mismatch($sformatf("depth_now %0d, expected %0d",
                                            rsp_depth_now, want.depth));
               end
            end
         end
         if (req_valid && !req_stall) begin
            pending_views.push_back(apply_opcode(req_type, req_push_value));
         end
      end
      pending_count = pending_views.size();
   end

endmodule

// ----- verif/tb_top.sv -----
// Top of the stack engine testbench: clock, reset, stimulus, back-pressure and verdict.
// Depends on sae_pkg, stack_alu_engine_core and stack_view_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sae_pkg::*;

   localparam int          STACK_ENTRIES = 64;
   localparam int          RANDOM_ITEMS  = 1250;
   localparam int          HOLD_AT       = 700;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          IDLE_LIMIT    = 4000;
   localparam int          DRAIN_CYCLES  = 60;
   localparam logic [3:0]  OPC_UNUSED    = 4'hF;
   localparam logic [31:0] WORD_MIN      = 32'h8000_0000;
   localparam logic [31:0] WORD_MAX      = 32'h7FFF_FFFF;
   localparam logic [31:0] WORD_M1       = 32'hFFFF_FFFF;

   typedef enum {SEG_FILL, SEG_DRAIN, SEG_MIX, SEG_OVERFILL} segment_kind_t;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [3:0]  req_type       = '0;
   logic [31:0] req_push_value = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_top_value;
   logic [6:0]  rsp_depth_now;
   int          fail_count;
   int          pending_count;
   bit          hold_request   = 1'b0;
   int          burst_left     = 1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   stack_alu_engine_core #(
      .STACK_DEPTH(STACK_ENTRIES)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_top_value  (rsp_top_value),
      .rsp_depth_now  (rsp_depth_now)
   );

   stack_view_checker #(
      .DEPTH(STACK_ENTRIES)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_top_value  (rsp_top_value),
      .rsp_depth_now  (rsp_depth_now),
      .fail_count     (fail_count),
      .pending_count  (pending_count)
   );

   // Offer one transaction and hold it until accepted. After each burst the
   // sender drops valid for a random gap, which may be zero.
   task automatic offer(input logic [3:0] opc, input logic [31:0] word);
      int gap;
      req_valid      <= 1'b1;
      req_type       <= opc;
      req_push_value <= word;
      do @(posedge clock); while (req_stall);
      burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(40, 1);
         gap        = ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(12, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Small values make zero divisors and sign corners frequent.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(9, 0))
         0, 1, 2, 3: return 32'($signed($urandom_range(18, 0)) - 9);
         4: begin
            case ($urandom_range(4, 0))
               0:       return WORD_MIN;
               1:       return WORD_MAX;
               2:       return WORD_M1;
               3:       return 32'd1;
               default: return 32'd0;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // Receiver back-pressure: a stall rate that is redrawn at random, plus one
   // long hold-off while the sender keeps offering.
   initial begin
      int  cycle;
      int  stall_pct;
      int  hold_left;
      bit  hold_done;
      cycle     = 0;
      stall_pct = 0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         cycle++;
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (cycle % 64 == 0) begin
            case ($urandom_range(4, 0))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 25;
               3:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99, 0) < stall_pct);
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int            sent;
      int            seg_left;
      int            push_pct;
      bit            overfilled;
      segment_kind_t seg_kind;
      logic [3:0]    opc;
      sent       = 0;
      seg_left   = 0;
      push_pct   = 50;
      overfilled = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: short-stack errors on an empty stack, then the sign and
      // wrap corners of each arithmetic operation.
      offer(OP_POP, '0);
      offer(OP_PEEK, '0);
      offer(OP_SWAP, '0);
      offer(OP_ADD, '0);
      offer(OP_PUSH, WORD_MIN);
      offer(OP_SWAP, '0);
      offer(OP_DIV, '0);
      offer(OP_PUSH, WORD_M1);
      offer(OP_DIV, '0);
      offer(OP_PUSH, WORD_M1);
      offer(OP_MOD, '0);
      offer(OP_PUSH, '0);
      offer(OP_DIV, '0);
      offer(OP_MOD, '0);
      offer(OP_PUSH, WORD_MAX);
      offer(OP_PUSH, 32'd1);
      offer(OP_ADD, '0);
      offer(OP_PUSH, -32'sd7);
      offer(OP_SUB, '0);
      offer(OP_SWAP, '0);
      offer(OP_POP, '0);
      offer(OP_PUSH, -32'sd2);
      offer(OP_MUL, '0);
      offer(OP_PEEK, '0);
      offer(OPC_UNUSED, $urandom());

      // Random: segments that grow, shrink or churn the stack. One segment
      // pushes past the top so the full-stack error is certain to occur.
      while (sent < RANDOM_ITEMS) begin
         if (seg_left == 0) begin
            if (sent >= 400 && !overfilled) begin
               seg_kind   = SEG_OVERFILL;
               overfilled = 1'b1;
            end else begin
               seg_kind = segment_kind_t'($urandom_range(2, 0));
            end
            case (seg_kind)
               SEG_FILL:     push_pct = 80;
               SEG_DRAIN:    push_pct = 15;
               SEG_MIX:      push_pct = 50;
               SEG_OVERFILL: push_pct = 100;
            endcase
            seg_left = (seg_kind == SEG_OVERFILL) ? 72 : $urandom_range(90, 20);
         end
         if ($urandom_range(99, 0) < push_pct) begin
            opc = OP_PUSH;
         end else if ($urandom_range(49, 0) == 0) begin
            opc = 4'($urandom_range(15, int'(OP_MOD) + 1));
         end else begin
            opc = 4'($urandom_range(int'(OP_MOD), int'(OP_POP)));
         end
         offer(opc, pick_word());
         sent++;
         seg_left--;
         if (sent == HOLD_AT) hold_request = 1'b1;
      end

      req_valid <= 1'b0;
      // Let the checker record the last accepted transaction before polling.
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sae_pkg.sv
rtl/sae_stack_mem.sv
rtl/sae_alu.sv
rtl/stack_alu_engine_core.sv
verif/stack_view_checker.sv
verif/tb_top.sv
